// ===== sv/aflm_pkg.sv =====
// Shared constants and types for the attitude fault and lap monitor.
`default_nettype none

package aflm_pkg;

   typedef logic [1:0]  csr_index_type;
   typedef logic [15:0] csr_data_type;
   typedef logic [1:0]  phase_type;

   // configuration register indexes
   localparam csr_index_type CSR_PITCH_THR = 2'd0;
   localparam csr_index_type CSR_YAW_THR   = 2'd1;
   localparam csr_index_type CSR_LAP_LIMIT = 2'd2;

   localparam phase_type PHASE_TAKEOFF = 2'd1;
   localparam phase_type PHASE_FLY     = 2'd2;

   localparam int SAMPLE_INTERVAL_MS_DEFAULT = 100;
   localparam int SLOW_YAW_LIMIT_DEFAULT     = 50;

   localparam int PITCH_THR_DEFAULT = 40;
   localparam int YAW_THR_DEFAULT   = 20;
   localparam int HALF_TURN         = 180;
   localparam int FULL_TURN         = 360;
   localparam int DEG_PER_TENTH     = 36;
   localparam int BURP_MARGIN       = 10;
   localparam int YAW_LOW_BAND      = 10;
   localparam int SET_COUNT         = 2;
   localparam int CLEAR_COUNT       = 5;
   localparam int MS_PER_S          = 1000;

endpackage

`default_nettype wire

// ===== sv/attitude_fault_and_lap_monitor.sv =====
// Attitude fault and lap monitor: top level.
//
// Usage: each sample (time, X/Y/Z angles, flight phase, switch, run flag)
// arrives as a valid/ready transfer on the req_ channel and yields exactly one
// result on the rsp_ channel. The first sample after reset primes the block;
// later samples are evaluated once SAMPLE_INTERVAL_MS has passed since the
// priming sample or the last evaluated sample. Thresholds and the lap
// limit are written through the csr_ channel, which is always ready; write
// them only while the block is idle. A sample taken on the req_ channel
// sits in the input register, then in the result register behind rsp_valid.
// Throughput: one sample per cycle while rsp_ready holds, set by the single
// pass of lap, pitch and yaw logic between those two registers, which also
// updates the running state so the next sample sees it straight away.
// A stalled receiver holds the result register; one more sample waits in the
// input register, after which req_ready drops until rsp_ready returns.
// Reset (synchronous, active high) empties both registers, clears the
// configuration registers, the lap count, all counters and the fault flags.
`default_nettype none

module attitude_fault_and_lap_monitor #(
   parameter int SAMPLE_INTERVAL_MS = aflm_pkg::SAMPLE_INTERVAL_MS_DEFAULT,
   parameter int SLOW_YAW_LIMIT     = aflm_pkg::SLOW_YAW_LIMIT_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // configuration writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  aflm_pkg::csr_index_type csr_index,
   input  aflm_pkg::csr_data_type csr_data,
   // samples
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [31:0]            req_time_ms,
   input  logic signed [15:0]     req_angle_x,
   input  logic signed [15:0]     req_angle_y,
   input  logic signed [15:0]     req_angle_z,
   input  aflm_pkg::phase_type    req_flight_phase,
   input  logic                   req_checks_switch_low,
   input  logic                   req_running,
   // results
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_evaluated,
   output logic                   rsp_stop_request,
   output logic                   rsp_burp_request,
   output logic                   rsp_pitch_fault,
   output logic                   rsp_yaw_fault,
   output logic                   rsp_yaw_low_fault,
   output logic [31:0]            rsp_lap_tenths
);

   import aflm_pkg::*;

   localparam int IW     = $clog2(SAMPLE_INTERVAL_MS + 1);
   localparam int MW     = $clog2(MS_PER_S + 1);
   localparam int YLIM_W = 12 + IW;
   localparam int YDZ_W  = 17 + MW;
   localparam int CMP_W  = (YLIM_W > YDZ_W) ? YLIM_W : YDZ_W;
   // m / 36 = (m >> 2) / 9, and n / 9 = (n * 7282) >> 16 for n below 2^15
   localparam int DIV9_RECIP = 7282;
   localparam int DIV9_SHIFT = 16;

   function automatic logic [3:0] inc4(input logic [3:0] c);
      return (c == 4'hF) ? c : c + 4'd1;
   endfunction

   // configuration
   logic [7:0]  pitch_thr_ff;
   logic [11:0] yaw_thr_ff;
   logic [15:0] lap_limit_ff;

   // input register
   logic               in_valid_ff, in_valid_in;
   logic [31:0]        in_time_ff;
   logic signed [15:0] in_x_ff, in_y_ff, in_z_ff;
   phase_type          in_phase_ff;
   logic               in_sw_low_ff, in_running_ff;

   // running state
   logic               primed_ff, primed_in;
   logic [31:0]        window_start_ff, window_start_in;
   logic signed [15:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in, prev_z_ff, prev_z_in;
   logic signed [17:0] lap_residue_ff, lap_residue_in;
   logic [31:0]        lap_total_ff, lap_total_in;
   logic [3:0]         pitch_set_ff, pitch_set_in, pitch_clear_ff, pitch_clear_in;
   logic [3:0]         yaw_high_ff, yaw_high_in, yaw_low_ff, yaw_low_in;
   logic [15:0]        yaw_slow_ff, yaw_slow_in;
   logic               flag_pitch_ff, flag_pitch_in;
   logic               flag_yaw_ff, flag_yaw_in;
   logic               flag_yaw_low_ff, flag_yaw_low_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_eval_ff, rsp_eval_in;
   logic        rsp_stop_ff, rsp_stop_in;
   logic        rsp_burp_ff, rsp_burp_in;
   logic        rsp_pitch_ff, rsp_yaw_ff, rsp_yaw_low_ff;
   logic [31:0] rsp_lap_ff;

   logic req_fire, advance;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // ---------------- datapath ----------------
   logic        window_open;
   assign window_open = (in_time_ff - window_start_ff) >= 32'(SAMPLE_INTERVAL_MS);

   // laps
   logic signed [16:0] dy_raw;
   logic signed [17:0] dy_wrap, res_sum, res_after;
   logic               res_neg, lap_step;
   logic [16:0]        res_mag, tenths_x36;
   logic [28:0]        div_prod;
   logic [10:0]        tenths;
   logic [5:0]         res_rem;
   logic [32:0]        total_sum;
   logic [31:0]        total_new;
   logic               limit_reached, burp_cond;

   assign dy_raw = 17'(in_y_ff) - 17'(prev_y_ff);
   always_comb begin
      if (dy_raw > HALF_TURN) begin
         dy_wrap = 18'(dy_raw) - 18'(FULL_TURN);
      end else if (dy_raw < -HALF_TURN) begin
         dy_wrap = 18'(dy_raw) + 18'(FULL_TURN);
      end else begin
         dy_wrap = 18'(dy_raw);
      end
   end
   assign res_sum    = lap_residue_ff + dy_wrap;
   assign res_neg    = res_sum[17];
   assign res_mag    = res_neg ? 17'(-res_sum) : 17'(res_sum);
   assign lap_step   = res_mag >= 17'(DEG_PER_TENTH);
   assign div_prod   = 29'(res_mag[16:2]) * 29'(DIV9_RECIP);
   assign tenths     = div_prod[DIV9_SHIFT +: 11];
   assign tenths_x36 = 17'(tenths) * 17'(DEG_PER_TENTH);
   assign res_rem    = 6'(res_mag - tenths_x36);
   assign res_after  = res_neg ? (18'd0 - 18'(res_rem)) : 18'(res_rem);
   assign total_sum  = {1'b0, lap_total_ff} + 33'(tenths);
   assign total_new  = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
   assign limit_reached = (lap_limit_ff != 16'd0) && (total_new >= 32'(lap_limit_ff));
   assign burp_cond = (lap_limit_ff >= 16'(BURP_MARGIN)) && (in_phase_ff == PHASE_FLY)
                      && in_running_ff && !limit_reached
                      && (total_new >= 32'(lap_limit_ff - 16'(BURP_MARGIN)));

   // pitch
   logic signed [16:0] dx_raw;
   logic [16:0]        adx;
   logic [7:0]         pthr;
   logic               pitch_high, pitch_quiet;

   assign dx_raw      = 17'(in_x_ff) - 17'(prev_x_ff);
   assign adx         = dx_raw[16] ? 17'(-dx_raw) : 17'(dx_raw);
   assign pthr        = (pitch_thr_ff == 8'd0) ? 8'(PITCH_THR_DEFAULT) : pitch_thr_ff;
   assign pitch_high  = adx >= 17'(pthr);
   assign pitch_quiet = adx < 17'(pthr >> 1);

   // yaw
   logic signed [16:0] dz_raw, z_wide;
   logic [16:0]        adz, z_mag;
   logic [11:0]        ythr;
   logic [CMP_W-1:0]   dz_scaled, yaw_limit;
   logic               yaw_rate_high, z_small, yaw_phase, checks_off;

   assign dz_raw        = 17'(in_z_ff) - 17'(prev_z_ff);
   assign adz           = dz_raw[16] ? 17'(-dz_raw) : 17'(dz_raw);
   assign z_wide        = 17'(in_z_ff);
   assign z_mag         = z_wide[16] ? 17'(-z_wide) : 17'(z_wide);
   assign ythr          = (yaw_thr_ff == 12'd0) ? 12'(YAW_THR_DEFAULT) : yaw_thr_ff;
   assign dz_scaled     = CMP_W'(adz) * CMP_W'(MS_PER_S);
   assign yaw_limit     = CMP_W'(ythr) * CMP_W'(SAMPLE_INTERVAL_MS);
   assign yaw_rate_high = dz_scaled >= yaw_limit;
   assign z_small       = z_mag <= 17'(YAW_LOW_BAND);
   assign yaw_phase     = (in_phase_ff == PHASE_TAKEOFF) || (in_phase_ff == PHASE_FLY);
   assign checks_off    = (in_phase_ff == PHASE_FLY) && in_sw_low_ff;

   // state update for the sample leaving the input register
   always_comb begin
      primed_in       = primed_ff;
      window_start_in = window_start_ff;
      prev_x_in       = prev_x_ff;
      prev_y_in       = prev_y_ff;
      prev_z_in       = prev_z_ff;
      lap_residue_in  = lap_residue_ff;
      lap_total_in    = lap_total_ff;
      pitch_set_in    = pitch_set_ff;
      pitch_clear_in  = pitch_clear_ff;
      yaw_high_in     = yaw_high_ff;
      yaw_low_in      = yaw_low_ff;
      yaw_slow_in     = yaw_slow_ff;
      flag_pitch_in   = flag_pitch_ff;
      flag_yaw_in     = flag_yaw_ff;
      flag_yaw_low_in = flag_yaw_low_ff;
      rsp_eval_in     = 1'b0;
      rsp_stop_in     = 1'b0;
      rsp_burp_in     = 1'b0;

      if (advance) begin
         if (!primed_ff) begin
            primed_in       = 1'b1;
            window_start_in = in_time_ff;
            prev_x_in       = in_x_ff;
            prev_y_in       = in_y_ff;
            prev_z_in       = in_z_ff;
            flag_pitch_in   = 1'b0;
            flag_yaw_in     = 1'b0;
            flag_yaw_low_in = 1'b0;
         end else if (window_open) begin
            rsp_eval_in     = 1'b1;
            window_start_in = in_time_ff;
            prev_x_in       = in_x_ff;
            prev_y_in       = in_y_ff;
            prev_z_in       = in_z_ff;

            if (lap_step) begin
               lap_total_in   = total_new;
               lap_residue_in = res_after;
               rsp_stop_in    = limit_reached;
               rsp_burp_in    = burp_cond;
            end else begin
               lap_residue_in = res_sum;
            end

            if (pitch_high) begin
               pitch_set_in   = inc4(pitch_set_ff);
               pitch_clear_in = 4'd0;
            end else begin
               pitch_set_in   = 4'd0;
               pitch_clear_in = pitch_quiet ? inc4(pitch_clear_ff) : 4'd0;
            end
            if (pitch_set_in >= 4'(SET_COUNT)) begin
               flag_pitch_in = 1'b1;
               rsp_stop_in   = 1'b1;
            end else if (pitch_clear_in >= 4'(CLEAR_COUNT)) begin
               flag_pitch_in = 1'b0;
            end

            if (yaw_phase) begin
               if (yaw_rate_high) begin
                  yaw_high_in = inc4(yaw_high_ff);
                  yaw_low_in  = 4'd0;
               end else if (z_small) begin
                  yaw_low_in  = inc4(yaw_low_ff);
                  yaw_high_in = 4'd0;
               end else begin
                  yaw_high_in = 4'd0;
                  yaw_low_in  = 4'd0;
               end
               if ((in_phase_ff == PHASE_TAKEOFF) && (yaw_slow_ff != 16'hFFFF)) begin
                  yaw_slow_in = yaw_slow_ff + 16'd1;
               end
               // with checks off a tripped counter leaves the flags alone
               if (yaw_high_in >= 4'(SET_COUNT)) begin
                  if (!checks_off) begin
                     flag_yaw_in = 1'b1;
                     rsp_stop_in = 1'b1;
                  end
               end else if (yaw_low_in >= 4'(CLEAR_COUNT)) begin
                  if (!checks_off) begin
                     flag_yaw_low_in = 1'b1;
                     rsp_stop_in     = 1'b1;
                  end
               end else if (yaw_slow_in >= 16'(SLOW_YAW_LIMIT)) begin
                  if (!checks_off) begin
                     flag_yaw_in = 1'b1;
                     rsp_stop_in = 1'b1;
                  end
               end else begin
                  flag_yaw_in     = 1'b0;
                  flag_yaw_low_in = 1'b0;
               end
            end else begin
               if (yaw_slow_ff != 16'd0) begin
                  yaw_slow_in = yaw_slow_ff - 16'd1;
               end
               yaw_high_in     = 4'd0;
               yaw_low_in      = 4'd0;
               flag_yaw_in     = 1'b0;
               flag_yaw_low_in = 1'b0;
            end
         end
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_thr_ff    <= 8'd0;
         yaw_thr_ff      <= 12'd0;
         lap_limit_ff    <= 16'd0;
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         primed_ff       <= 1'b0;
         window_start_ff <= 32'd0;
         prev_x_ff       <= 16'sd0;
         prev_y_ff       <= 16'sd0;
         prev_z_ff       <= 16'sd0;
         lap_residue_ff  <= 18'sd0;
         lap_total_ff    <= 32'd0;
         pitch_set_ff    <= 4'd0;
         pitch_clear_ff  <= 4'd0;
         yaw_high_ff     <= 4'd0;
         yaw_low_ff      <= 4'd0;
         yaw_slow_ff     <= 16'd0;
         flag_pitch_ff   <= 1'b0;
         flag_yaw_ff     <= 1'b0;
         flag_yaw_low_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_PITCH_THR: pitch_thr_ff <= csr_data[7:0];
               CSR_YAW_THR:   yaw_thr_ff   <= csr_data[11:0];
               CSR_LAP_LIMIT: lap_limit_ff <= csr_data;
               default: ;
            endcase
         end
         in_valid_ff     <= in_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         primed_ff       <= primed_in;
         window_start_ff <= window_start_in;
         prev_x_ff       <= prev_x_in;
         prev_y_ff       <= prev_y_in;
         prev_z_ff       <= prev_z_in;
         lap_residue_ff  <= lap_residue_in;
         lap_total_ff    <= lap_total_in;
         pitch_set_ff    <= pitch_set_in;
         pitch_clear_ff  <= pitch_clear_in;
         yaw_high_ff     <= yaw_high_in;
         yaw_low_ff      <= yaw_low_in;
         yaw_slow_ff     <= yaw_slow_in;
         flag_pitch_ff   <= flag_pitch_in;
         flag_yaw_ff     <= flag_yaw_in;
         flag_yaw_low_ff <= flag_yaw_low_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_time_ff    <= req_time_ms;
         in_x_ff       <= req_angle_x;
         in_y_ff       <= req_angle_y;
         in_z_ff       <= req_angle_z;
         in_phase_ff   <= req_flight_phase;
         in_sw_low_ff  <= req_checks_switch_low;
         in_running_ff <= req_running;
      end
      if (advance) begin
         rsp_eval_ff    <= rsp_eval_in;
         rsp_stop_ff    <= rsp_stop_in;
         rsp_burp_ff    <= rsp_burp_in;
         rsp_pitch_ff   <= flag_pitch_in;
         rsp_yaw_ff     <= flag_yaw_in;
         rsp_yaw_low_ff <= flag_yaw_low_in;
         rsp_lap_ff     <= lap_total_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_evaluated     = rsp_eval_ff;
   assign rsp_stop_request  = rsp_stop_ff;
   assign rsp_burp_request  = rsp_burp_ff;
   assign rsp_pitch_fault   = rsp_pitch_ff;
   assign rsp_yaw_fault     = rsp_yaw_ff;
   assign rsp_yaw_low_fault = rsp_yaw_low_ff;
   assign rsp_lap_tenths    = rsp_lap_ff;

   // ---------------- assertions ----------------
   a_idle_result_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_eval_ff |-> !rsp_stop_ff && !rsp_burp_ff)
      else $error("stop or burp on a sample that closed no window");

   a_lap_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> lap_total_ff >= $past(lap_total_ff))
      else $error("lap count went backwards");

   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && rsp_valid_ff && !rsp_ready)
      else $error("input held off without a full pipeline");

endmodule

`default_nettype wire

// ===== verif/tb_attitude_fault_and_lap_monitor.sv =====
// Self-checking testbench for the attitude fault and lap monitor.
`timescale 1ns / 1ps

module tb_attitude_fault_and_lap_monitor;
   import aflm_pkg::*;

   localparam int SAMPLE_INTERVAL_MS = SAMPLE_INTERVAL_MS_DEFAULT;
   localparam int SLOW_YAW_LIMIT     = SLOW_YAW_LIMIT_DEFAULT;
   localparam int CYCLE_LIMIT        = 400000;

   localparam phase_type PHASE_OTHER = 2'd0;
   localparam phase_type PHASE_BURP  = 2'd3;

   typedef struct {
      logic [31:0]        time_ms;
      logic signed [15:0] angle_x;
      logic signed [15:0] angle_y;
      logic signed [15:0] angle_z;
      phase_type          phase;
      logic               switch_low;
      logic               running;
   } attitude_sample_type;

   typedef struct {
      logic        evaluated;
      logic        stop_request;
      logic        burp_request;
      logic        pitch_fault;
      logic        yaw_fault;
      logic        yaw_low_fault;
      logic [31:0] lap_tenths;
   } monitor_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_PITCH_THR;
   csr_data_type  csr_data  = '0;

   logic               req_valid             = 1'b0;
   logic               req_ready;
   logic [31:0]        req_time_ms           = '0;
   logic signed [15:0] req_angle_x           = '0;
   logic signed [15:0] req_angle_y           = '0;
   logic signed [15:0] req_angle_z           = '0;
   phase_type          req_flight_phase      = PHASE_OTHER;
   logic               req_checks_switch_low = 1'b0;
   logic               req_running           = 1'b0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_evaluated;
   logic        rsp_stop_request;
   logic        rsp_burp_request;
   logic        rsp_pitch_fault;
   logic        rsp_yaw_fault;
   logic        rsp_yaw_low_fault;
   logic [31:0] rsp_lap_tenths;

   attitude_fault_and_lap_monitor #(
      .SAMPLE_INTERVAL_MS (SAMPLE_INTERVAL_MS),
      .SLOW_YAW_LIMIT     (SLOW_YAW_LIMIT)
   ) dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_time_ms           (req_time_ms),
      .req_angle_x           (req_angle_x),
      .req_angle_y           (req_angle_y),
      .req_angle_z           (req_angle_z),
      .req_flight_phase      (req_flight_phase),
      .req_checks_switch_low (req_checks_switch_low),
      .req_running           (req_running),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_evaluated         (rsp_evaluated),
      .rsp_stop_request      (rsp_stop_request),
      .rsp_burp_request      (rsp_burp_request),
      .rsp_pitch_fault       (rsp_pitch_fault),
      .rsp_yaw_fault         (rsp_yaw_fault),
      .rsp_yaw_low_fault     (rsp_yaw_low_fault),
      .rsp_lap_tenths        (rsp_lap_tenths)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------
   // Monitor state mirror: configuration and running state
   // ---------------------------------------------------------------
   logic [7:0]  cfg_pitch_deg = '0;
   logic [11:0] cfg_yaw_rate  = '0;
   logic [15:0] cfg_lap_limit = '0;

   logic               seen_first     = 1'b0;
   logic [31:0]        window_begin   = '0;
   logic signed [15:0] last_x         = '0;
   logic signed [15:0] last_y         = '0;
   logic signed [15:0] last_z         = '0;
   int                 lap_remainder  = 0;
   logic [31:0]        lap_count      = '0;
   logic [3:0]         pitch_trip_run = '0;
   logic [3:0]         pitch_calm_run = '0;
   logic [3:0]         yaw_fast_run   = '0;
   logic [3:0]         yaw_still_run  = '0;
   logic [15:0]        takeoff_dwell  = '0;
   logic               pitch_flag     = 1'b0;
   logic               yaw_flag       = 1'b0;
   logic               yaw_low_flag   = 1'b0;

   attitude_sample_type pending_samples[$];
   monitor_result_type  expected_results[$];

   int   mismatch_count  = 0;
   int   samples_taken   = 0;
   int   results_checked = 0;
   int   evaluations     = 0;
   int   stops_seen      = 0;
   int   burps_seen      = 0;
   int   faults_seen     = 0;
   int   settings_used   = 1;
   int   cycle_count     = 0;
   int   send_gap        = 0;
   int   stall_left      = 0;
   bit   calm_tail       = 1'b0;
   logic req_fired       = 1'b0;

   // stimulus trackers
   logic [31:0]        stim_time = '0;
   int                 x_track   = 0;
   logic signed [15:0] y_track   = '0;
   int                 z_track   = 0;

   function automatic int magnitude(int v);
      return v < 0 ? -v : v;
   endfunction

   function automatic logic [3:0] bump4(logic [3:0] c);
      return c == 4'hF ? c : c + 4'd1;
   endfunction

   // Advances the mirrored state by one accepted sample and returns its result.
   function automatic monitor_result_type predict_result(attitude_sample_type s);
      monitor_result_type r;
      logic [31:0]     elapsed;
      logic [63:0]     lap_sum;
      int              dx, dy, dz, adx, tenths, pitch_limit, yaw_limit;
      logic            run_ok, checks_off;
      r = '{default: '0};
      run_ok = s.running;
      elapsed = s.time_ms - window_begin;
      if (!seen_first) begin
         seen_first = 1'b1;
         window_begin = s.time_ms;
         last_x = s.angle_x;
         last_y = s.angle_y;
         last_z = s.angle_z;
         pitch_flag = 1'b0;
         yaw_flag = 1'b0;
         yaw_low_flag = 1'b0;
      end else if (elapsed >= SAMPLE_INTERVAL_MS) begin
         r.evaluated = 1'b1;
         dx = int'(s.angle_x) - int'(last_x);
         dy = int'(s.angle_y) - int'(last_y);
         dz = int'(s.angle_z) - int'(last_z);

         // laps: Y delta folded once into the half-turn range
         if (dy > HALF_TURN) dy -= FULL_TURN;
         else if (dy < -HALF_TURN) dy += FULL_TURN;
         lap_remainder += dy;
         if (magnitude(lap_remainder) >= DEG_PER_TENTH) begin
            tenths = magnitude(lap_remainder) / DEG_PER_TENTH;
            lap_sum = {32'd0, lap_count} + 64'(tenths);
            lap_count = lap_sum > 64'h0000_0000_FFFF_FFFF ? '1 : lap_sum[31:0];
            if (cfg_lap_limit != 0 && lap_count >= cfg_lap_limit) begin
               r.stop_request = 1'b1;
               run_ok = 1'b0;
            end
            if (cfg_lap_limit >= BURP_MARGIN && s.phase == PHASE_FLY && run_ok &&
                lap_count >= 32'(cfg_lap_limit) - BURP_MARGIN)
               r.burp_request = 1'b1;
            if (lap_remainder > 0) lap_remainder -= tenths * DEG_PER_TENTH;
            else lap_remainder += tenths * DEG_PER_TENTH;
         end

         // pitch hysteresis
         pitch_limit = cfg_pitch_deg != 0 ? int'(cfg_pitch_deg) : PITCH_THR_DEFAULT;
         adx = magnitude(dx);
         if (adx >= pitch_limit) begin
            pitch_trip_run = bump4(pitch_trip_run);
            pitch_calm_run = '0;
         end else begin
            pitch_trip_run = '0;
            if (adx < pitch_limit / 2) pitch_calm_run = bump4(pitch_calm_run);
            else pitch_calm_run = '0;
         end
         if (pitch_trip_run >= SET_COUNT) begin
            pitch_flag = 1'b1;
            r.stop_request = 1'b1;
         end else if (pitch_calm_run >= CLEAR_COUNT) begin
            pitch_flag = 1'b0;
         end

         // yaw checks only in takeoff and fly
         if (s.phase == PHASE_TAKEOFF || s.phase == PHASE_FLY) begin
            yaw_limit = cfg_yaw_rate != 0 ? int'(cfg_yaw_rate) : YAW_THR_DEFAULT;
            checks_off = (s.phase == PHASE_FLY) && s.switch_low;
            if (magnitude(dz) * MS_PER_S >= yaw_limit * SAMPLE_INTERVAL_MS) begin
               yaw_fast_run = bump4(yaw_fast_run);
               yaw_still_run = '0;
            end else if (magnitude(int'(s.angle_z)) <= YAW_LOW_BAND) begin
               yaw_still_run = bump4(yaw_still_run);
               yaw_fast_run = '0;
            end else begin
               yaw_fast_run = '0;
               yaw_still_run = '0;
            end
            if (s.phase == PHASE_TAKEOFF && takeoff_dwell != 16'hFFFF)
               takeoff_dwell = takeoff_dwell + 16'd1;
            if (yaw_fast_run >= SET_COUNT) begin
               if (!checks_off) begin
                  yaw_flag = 1'b1;
                  r.stop_request = 1'b1;
               end
            end else if (yaw_still_run >= CLEAR_COUNT) begin
               if (!checks_off) begin
                  yaw_low_flag = 1'b1;
                  r.stop_request = 1'b1;
               end
            end else if (takeoff_dwell >= SLOW_YAW_LIMIT) begin
               if (!checks_off) begin
                  yaw_flag = 1'b1;
                  r.stop_request = 1'b1;
               end
            end else begin
               yaw_flag = 1'b0;
               yaw_low_flag = 1'b0;
            end
         end else begin
            if (takeoff_dwell != 0) takeoff_dwell = takeoff_dwell - 16'd1;
            yaw_fast_run = '0;
            yaw_still_run = '0;
            yaw_flag = 1'b0;
            yaw_low_flag = 1'b0;
         end

         last_x = s.angle_x;
         last_y = s.angle_y;
         last_z = s.angle_z;
         window_begin = s.time_ms;
      end
      r.pitch_fault = pitch_flag;
      r.yaw_fault = yaw_flag;
      r.yaw_low_fault = yaw_low_flag;
      r.lap_tenths = lap_count;
      return r;
   endfunction

   task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
   endtask

   // ---------------------------------------------------------------
   // Sample driver: inputs change on the falling edge
   // ---------------------------------------------------------------
   always @(negedge clock) begin : sample_driver
      attitude_sample_type item_out;
      if (!reset && (!req_valid || req_fired)) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (pending_samples.size() > 0) begin
            item_out = pending_samples.pop_front();
            req_valid <= 1'b1;
            req_time_ms <= item_out.time_ms;
            req_angle_x <= item_out.angle_x;
            req_angle_y <= item_out.angle_y;
            req_angle_z <= item_out.angle_z;
            req_flight_phase <= item_out.phase;
            req_checks_switch_low <= item_out.switch_low;
            req_running <= item_out.running;
            if (!calm_tail && $urandom_range(0, 7) == 0)
               send_gap <= $urandom_range(1, 13);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver back-pressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= $urandom_range(0, 12);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------
   // Monitor: every transfer sampled on the rising edge
   // ---------------------------------------------------------------
   always @(posedge clock) begin : transfer_monitor
      attitude_sample_type taken;
      monitor_result_type  want, got;
      req_fired <= req_valid && req_ready;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PITCH_THR: cfg_pitch_deg = csr_data[7:0];
               CSR_YAW_THR:   cfg_yaw_rate = csr_data[11:0];
               CSR_LAP_LIMIT: cfg_lap_limit = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            taken.time_ms = req_time_ms;
            taken.angle_x = req_angle_x;
            taken.angle_y = req_angle_y;
            taken.angle_z = req_angle_z;
            taken.phase = req_flight_phase;
            taken.switch_low = req_checks_switch_low;
            taken.running = req_running;
            want = predict_result(taken);
            expected_results.push_back(want);
            samples_taken++;
            evaluations += want.evaluated;
            stops_seen += want.stop_request;
            burps_seen += want.burp_request;
            faults_seen += want.pitch_fault | want.yaw_fault | want.yaw_low_fault;
         end
         if (rsp_valid && rsp_ready) begin
            got.evaluated = rsp_evaluated;
            got.stop_request = rsp_stop_request;
            got.burp_request = rsp_burp_request;
            got.pitch_fault = rsp_pitch_fault;
            got.yaw_fault = rsp_yaw_fault;
            got.yaw_low_fault = rsp_yaw_low_fault;
            got.lap_tenths = rsp_lap_tenths;
            if (expected_results.size() == 0) begin
               mismatch_count++;
               $display("%0t ns: result transfer with nothing expected", $time);
            end else begin
               want = expected_results.pop_front();
               results_checked++;
               if (got.evaluated !== want.evaluated)
                  report_field("evaluated", want.evaluated, got.evaluated);
               if (got.stop_request !== want.stop_request)
                  report_field("stop_request", want.stop_request, got.stop_request);
               if (got.burp_request !== want.burp_request)
                  report_field("burp_request", want.burp_request, got.burp_request);
               if (got.pitch_fault !== want.pitch_fault)
                  report_field("pitch_fault", want.pitch_fault, got.pitch_fault);
               if (got.yaw_fault !== want.yaw_fault)
                  report_field("yaw_fault", want.yaw_fault, got.yaw_fault);
               if (got.yaw_low_fault !== want.yaw_low_fault)
                  report_field("yaw_low_fault", want.yaw_low_fault, got.yaw_low_fault);
               if (got.lap_tenths !== want.lap_tenths)
                  report_field("lap_tenths", want.lap_tenths, got.lap_tenths);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles, %0d results outstanding",
                  cycle_count, expected_results.size());
         $display("attitude_fault_and_lap_monitor test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   task automatic push_sample(input int dt, input int x, input int y, input int z,
                              input phase_type ph, input logic sw, input logic run);
      attitude_sample_type s;
      stim_time = stim_time + dt;
      s.time_ms = stim_time;
      s.angle_x = 16'(x);
      s.angle_y = 16'(y);
      s.angle_z = 16'(z);
      s.phase = ph;
      s.switch_low = sw;
      s.running = run;
      pending_samples.push_back(s);
   endtask

   // One flight segment: a steady phase and manoeuvre style, with some noise mixed in.
   task automatic queue_segment(output int seg_len);
      phase_type seg_phase, ph;
      logic      seg_sw;
      int        pitch_style, yaw_style, y_dir, dt, roll, i;
      roll = $urandom_range(0, 9);
      seg_phase = roll == 0 ? PHASE_OTHER : roll == 1 ? PHASE_BURP :
                  roll < 6 ? PHASE_TAKEOFF : PHASE_FLY;
      // long takeoff stretches are needed to reach the slow-yaw limit
      seg_len = (seg_phase == PHASE_TAKEOFF && $urandom_range(0, 2) == 0) ?
                60 : $urandom_range(4, 40);
      seg_sw = $urandom_range(0, 3) == 0;
      pitch_style = $urandom_range(0, 2);
      yaw_style = $urandom_range(0, 3);
      y_dir = $urandom_range(0, 1) ? 1 : -1;
      if (yaw_style == 0) z_track = int'($urandom_range(0, 20)) - 10;
      if (yaw_style == 2)
         z_track = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(20, 500));
      for (i = 0; i < seg_len; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            x_track = $signed(16'($urandom()));
            z_track = $signed(16'($urandom()));
            if ($urandom_range(0, 3) == 0) y_track = 16'($urandom());
            dt = $urandom_range(0, 3) == 0 ? int'($urandom()) : int'($urandom_range(0, 300));
            push_sample(dt, x_track, int'(y_track), z_track, phase_type'($urandom()),
                        1'($urandom()), 1'($urandom()));
         end else begin
            roll = $urandom_range(0, 19);
            dt = roll < 2 ? int'($urandom_range(0, 99)) :
                 roll == 2 ? int'($urandom_range(100, 100000)) :
                 int'($urandom_range(100, 130));
            case (pitch_style)
               0: x_track += int'($urandom_range(0, 6)) - 3;
               1: x_track = x_track > 0 ? -int'($urandom_range(20, 200)) :
                            int'($urandom_range(20, 200));
               default: x_track += int'($urandom_range(0, 100)) - 50;
            endcase
            y_track = 16'(int'(y_track) + y_dir * int'($urandom_range(0, 60)));
            case (yaw_style)
               0: begin
                  z_track += int'($urandom_range(0, 2)) - 1;
                  if (z_track > YAW_LOW_BAND) z_track = YAW_LOW_BAND;
                  if (z_track < -YAW_LOW_BAND) z_track = -YAW_LOW_BAND;
               end
               1: z_track += ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(1, 400));
               2: z_track += int'($urandom_range(0, 2)) - 1;
               default: z_track = $signed(16'($urandom()));
            endcase
            ph = $urandom_range(0, 15) == 0 ? phase_type'($urandom()) : seg_phase;
            push_sample(dt, x_track, int'(y_track), z_track, ph,
                        $urandom_range(0, 7) == 0 ? ~seg_sw : seg_sw,
                        $urandom_range(0, 19) != 0);
         end
      end
   endtask

   task automatic queue_random_phase(int n_items);
      int queued, seg_len;
      queued = 0;
      while (queued < n_items) begin
         queue_segment(seg_len);
         queued += seg_len;
      end
   endtask

   task automatic wait_until_drained();
      do @(posedge clock);
      while (pending_samples.size() != 0 || expected_results.size() != 0 || req_valid);
   endtask

   task automatic write_register(csr_index_type idx, csr_data_type value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // lap limit a little ahead of the current count, so burp and stop both show up
   function automatic csr_data_type laps_ahead(int margin);
      logic [32:0] target;
      target = lap_count + margin;
      return target > 33'hFFFF ? 16'hFFFF : target[15:0];
   endfunction

   task automatic set_registers(csr_data_type pitch, csr_data_type yaw, csr_data_type laps);
      write_register(CSR_PITCH_THR, pitch);
      write_register(CSR_YAW_THR, yaw);
      write_register(CSR_LAP_LIMIT, laps);
      settings_used++;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: priming, window edges, wrap of Y, fault set and clear paths
      stim_time = 32'hFFFF_FFC0;
      push_sample(0, -32768, 32767, -32768, PHASE_BURP, 1'b1, 1'b0);
      push_sample(99, 0, 0, 0, PHASE_FLY, 1'b0, 1'b1);          // interval not yet elapsed
      push_sample(1, 32767, -32768, 32767, PHASE_TAKEOFF, 1'b0, 1'b1);
      push_sample(100, -32768, -32587, -32768, PHASE_FLY, 1'b1, 1'b1); // checks off
      push_sample(150, 0, -32768, 0, PHASE_FLY, 1'b0, 1'b0);    // stop while not running
      push_sample(100, 0, -32588, 5, PHASE_OTHER, 1'b0, 1'b1);
      push_sample(100, 0, -32768, 5, PHASE_TAKEOFF, 1'b0, 1'b1);
      push_sample(100, 0, -32588, 4, PHASE_TAKEOFF, 1'b0, 1'b1);
      push_sample(100, 0, -32768, 4, PHASE_TAKEOFF, 1'b0, 1'b1);
      push_sample(100, 0, -32588, 3, PHASE_TAKEOFF, 1'b0, 1'b1);
      push_sample(100, 0, -32768, 3, PHASE_TAKEOFF, 1'b0, 1'b1); // yaw too low
      push_sample(100, 0, -32588, 4, PHASE_TAKEOFF, 1'b0, 1'b1); // rate just under
      push_sample(100, 0, -32768, 6, PHASE_TAKEOFF, 1'b0, 1'b1); // rate exactly at
      push_sample(100, 0, -32588, 8, PHASE_TAKEOFF, 1'b0, 1'b1);
      push_sample(100, 0, -32768, 30, PHASE_FLY, 1'b1, 1'b1);
      push_sample(99, 0, -32588, 30, PHASE_FLY, 1'b0, 1'b1);
      push_sample(1, 0, -32588, 30, PHASE_FLY, 1'b0, 1'b1);
      wait_until_drained();

      set_registers(16'd1, 16'd1, laps_ahead(40));
      queue_random_phase(130);
      wait_until_drained();

      set_registers(16'd180, 16'd3600, 16'hFFFF);
      queue_random_phase(130);
      wait_until_drained();

      set_registers(16'($urandom_range(2, 179)), 16'($urandom_range(2, 3599)),
                    laps_ahead($urandom_range(10, 80)));
      queue_random_phase(130);
      wait_until_drained();

      set_registers(16'd0, 16'd0, 16'd10);
      queue_random_phase(130);
      wait_until_drained();

      set_registers(16'($urandom_range(0, 180)), 16'($urandom_range(0, 100)), 16'd1);
      queue_random_phase(130);
      wait_until_drained();

      // closing phase runs without any idling on either side
      calm_tail = 1'b1;
      set_registers(16'(PITCH_THR_DEFAULT), 16'(YAW_THR_DEFAULT), laps_ahead(60));
      queue_random_phase(130);
      wait_until_drained();
      repeat (10) @(posedge clock);

      $display("Checked %0d results for %0d samples over %0d register settings.",
               results_checked, samples_taken, settings_used);
      $display("%0d evaluations, %0d stop and %0d burp requests, %0d with a fault flag.",
               evaluations, stops_seen, burps_seen, faults_seen);
      if (mismatch_count == 0) begin
         $display("attitude_fault_and_lap_monitor test passed");
      end else begin
         $display("attitude_fault_and_lap_monitor test failed");
      end
      $finish;
   end

endmodule
